// ===== sv/ctgc_pkg.sv =====
`timescale 1ns / 1ps

package ctgc_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 8;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;

    localparam int DIM_W   = 7;
    localparam int COORD_W = 16;
    localparam int RAD_W   = 11;

    // tile index: floor of (coord +/- radius) >> FRAC_BITS
    localparam int TILE_W = COORD_W + 1 - FRAC_BITS;
    // fixed-point working width for tile edges
    localparam int FIX_W  = TILE_W + FRAC_BITS + 1;
    // clamped distance along one axis, bounded by the radius
    localparam int DIST_W = RAD_W + 1;
    localparam int SQ_W   = 2 * DIST_W - 1;
    localparam int R2_W   = 2 * (RAD_W - 1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
    localparam logic [DIM_W-1:0] COLS_MAX  = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] ROWS_MAX  = DIM_W'(MAX_ROWS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic clr_we;
        logic issue;
        logic finish;
    } t_ctrl;

endpackage

// ===== sv/circle_tile_grid_collision_core.sv =====
`timescale 1ns / 1ps

// Write request: taken while idle, no result; busy stays low.
// Query request: o_done strobes after setup, a walk of the N tiles in the bounding
// box (at most 81) and a drain of the check pipeline; one bitmap read per tile
// sets the pace. Negative radius: no walk, o_fits low. One request at a time.
// Reset (synchronous, active low) runs a clearing pass setting every tile blocked;
// busy is high meanwhile. Results are not stalled by the receiver.
module circle_tile_grid_collision_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [ctgc_pkg::COL_W-1:0]    i_tile_col,
    input  logic [ctgc_pkg::ROW_W-1:0]    i_tile_row,
    input  logic                          i_tile_is_wall,
    input  logic signed [ctgc_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [ctgc_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [ctgc_pkg::RAD_W-1:0]   i_circle_radius,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ctgc_pkg::DIM_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic                          o_fits
);
    import ctgc_pkg::*;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [DIM_W-1:0] r_map_width, r_map_height;
    logic [DIM_W-1:0] w_eff, h_eff;

    logic [ADDR_W-1:0] r_clr;

    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [RAD_W-1:0]   r_r;
    logic [R2_W-1:0]           r_r2;

    logic signed [TILE_W-1:0] r_x0, r_x1, r_y1, r_tx, r_ty;
    logic signed [COORD_W:0]  lo_x, hi_x, lo_y, hi_y;

    logic                     r_p1_valid, r_p1_oob;
    logic signed [DIST_W-1:0] r_p1_dx, r_p1_dy;
    logic                     r_p2_valid, r_p2_blk;
    logic [SQ_W-1:0]          r_p2_sqx, r_p2_sqy;
    logic                     r_hit;
    logic                     r_done, r_fits;

    logic                     accept;
    logic                     cur_oob;
    logic signed [FIX_W-1:0]  cx_f, cy_f, tlo_x, thi_x, tlo_y, thi_y, dx_f, dy_f;
    logic signed [2*DIST_W-1:0] prod_x, prod_y;
    logic [SQ_W:0]            dist2;

    logic                     mem [DEPTH];
    logic                     r_rd;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic                     wr_en, wr_data;

    assign accept = start && !busy;
    assign busy   = ctrl.busy;
    assign o_done = r_done;
    assign o_fits = r_fits;

    assign w_eff = (r_map_width  > COLS_MAX) ? COLS_MAX : r_map_width;
    assign h_eff = (r_map_height > ROWS_MAX) ? ROWS_MAX : r_map_height;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == ADDR_W'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept && i_opcode == OP_QUERY) n_state = ST_SETUP;
            ST_SETUP: n_state = r_r[RAD_W-1] ? ST_DRAIN : ST_WALK;
            ST_WALK:  if (r_tx == r_x1 && r_ty == r_y1) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_p1_valid && !r_p2_valid) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ctrl.busy   = 1'b1;
                ctrl.clr_we = 1'b1;
            end
            ST_IDLE:  ctrl.busy = 1'b0;
            ST_SETUP: ctrl.busy = 1'b1;
            ST_WALK: begin
                ctrl.busy  = 1'b1;
                ctrl.issue = 1'b1;
            end
            ST_DRAIN: begin
                ctrl.busy   = 1'b1;
                ctrl.finish = !r_p1_valid && !r_p2_valid;
            end
            default:  ctrl.busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= DIM_RESET;
            r_map_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) r_map_width <= i_cfg_data;
            if (i_cfg_idx == REG_HEIGHT) r_map_height <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (ctrl.clr_we) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // bitmap
    assign wr_en   = ctrl.clr_we || (accept && i_opcode == OP_WRITE);
    assign wr_addr = ctrl.clr_we ? r_clr : {i_tile_row, i_tile_col};
    assign wr_data = ctrl.clr_we ? 1'b1 : i_tile_is_wall;
    assign rd_addr = {r_ty[ROW_W-1:0], r_tx[COL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
    end

    // query setup
    assign lo_x = {r_cx[COORD_W-1], r_cx} - {{(COORD_W+1-RAD_W){r_r[RAD_W-1]}}, r_r};
    assign hi_x = {r_cx[COORD_W-1], r_cx} + {{(COORD_W+1-RAD_W){r_r[RAD_W-1]}}, r_r};
    assign lo_y = {r_cy[COORD_W-1], r_cy} - {{(COORD_W+1-RAD_W){r_r[RAD_W-1]}}, r_r};
    assign hi_y = {r_cy[COORD_W-1], r_cy} + {{(COORD_W+1-RAD_W){r_r[RAD_W-1]}}, r_r};

    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_QUERY) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_r  <= i_circle_radius;
        end
        if (ctrl.issue) begin
            if (r_tx == r_x1) begin
                r_tx <= r_x0;
                r_ty <= r_ty + 1'b1;
            end else begin
                r_tx <= r_tx + 1'b1;
            end
        end else if (r_state == ST_SETUP) begin
            r_x0 <= lo_x[COORD_W:FRAC_BITS];
            r_x1 <= hi_x[COORD_W:FRAC_BITS];
            r_y1 <= hi_y[COORD_W:FRAC_BITS];
            r_tx <= lo_x[COORD_W:FRAC_BITS];
            r_ty <= lo_y[COORD_W:FRAC_BITS];
            r_r2 <= r_r[RAD_W-2:0] * r_r[RAD_W-2:0];
        end
    end

    // per-tile clamp distance
    assign cx_f  = FIX_W'(r_cx);
    assign cy_f  = FIX_W'(r_cy);
    assign tlo_x = FIX_W'($signed({r_tx, {FRAC_BITS{1'b0}}}));
    assign thi_x = tlo_x + FIX_W'(1 << FRAC_BITS);
    assign tlo_y = FIX_W'($signed({r_ty, {FRAC_BITS{1'b0}}}));
    assign thi_y = tlo_y + FIX_W'(1 << FRAC_BITS);

    always_comb begin
        if (cx_f < tlo_x)      dx_f = cx_f - tlo_x;
        else if (cx_f > thi_x) dx_f = cx_f - thi_x;
        else                   dx_f = '0;
        if (cy_f < tlo_y)      dy_f = cy_f - tlo_y;
        else if (cy_f > thi_y) dy_f = cy_f - thi_y;
        else                   dy_f = '0;
    end

    assign cur_oob = r_tx[TILE_W-1] || r_ty[TILE_W-1]
                  || (r_tx >= $signed({{(TILE_W-DIM_W){1'b0}}, w_eff}))
                  || (r_ty >= $signed({{(TILE_W-DIM_W){1'b0}}, h_eff}));

    assign prod_x = r_p1_dx * r_p1_dx;
    assign prod_y = r_p1_dy * r_p1_dy;
    assign dist2  = {1'b0, r_p2_sqx} + {1'b0, r_p2_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_done     <= 1'b0;
            r_fits     <= 1'b0;
        end else begin
            r_p1_valid <= ctrl.issue;
            r_p2_valid <= r_p1_valid;
            r_done     <= ctrl.finish;
            if (ctrl.finish) r_fits <= !r_hit;
            if (r_state == ST_SETUP) begin
                r_hit <= r_r[RAD_W-1];
            end else if (r_p2_valid && r_p2_blk
                         && dist2 < {{(SQ_W+1-R2_W){1'b0}}, r_r2}) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_oob <= cur_oob;
        r_p1_dx  <= dx_f[DIST_W-1:0];
        r_p1_dy  <= dy_f[DIST_W-1:0];
        r_p2_blk <= r_p1_oob || r_rd;
        r_p2_sqx <= prod_x[SQ_W-1:0];
        r_p2_sqy <= prod_y[SQ_W-1:0];
    end

endmodule

// ===== sv/ctgc_checker.sv =====
`timescale 1ns / 1ps

module ctgc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_opcode,
    input logic o_done
);
    import ctgc_pkg::*;

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode == OP_QUERY |=> busy)
        else $error("query request did not raise busy");

    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_opcode == OP_WRITE |=> !busy && !o_done)
        else $error("write request produced a result or busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result without preceding work");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

bind circle_tile_grid_collision_core ctgc_checker u_ctgc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_done   (o_done)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ctgc_pkg::*;

    typedef struct {
        logic                      op;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic                      wall;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [RAD_W-1:0]   rad;
        bit                        known;
        logic                      fits;
    } t_req;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_opcode = OP_WRITE;
    logic [COL_W-1:0]          i_tile_col = '0;
    logic [ROW_W-1:0]          i_tile_row = '0;
    logic                      i_tile_is_wall = 1'b0;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic signed [RAD_W-1:0]   i_circle_radius = '0;
    logic                      i_cfg_we = 1'b0;
    logic                      i_cfg_idx = REG_WIDTH;
    logic [DIM_W-1:0]          i_cfg_data = '0;
    logic                      o_done;
    logic                      o_fits;

    bit               wall_map [DEPTH];
    logic [DIM_W-1:0] map_w;
    logic [DIM_W-1:0] map_h;
    logic             fits_due [$];
    int               bad_count = 0;
    int               hot_x;
    int               hot_y;
    t_req             directed_reqs [$];

    circle_tile_grid_collision_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_tile_col      (i_tile_col),
        .i_tile_row      (i_tile_row),
        .i_tile_is_wall  (i_tile_is_wall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_fits          (o_fits)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // walk the floor-rounded bounding box; out-of-map tiles are blocked
    function automatic logic predict_fits(logic signed [COORD_W-1:0] cx_i,
                                          logic signed [COORD_W-1:0] cy_i,
                                          logic signed [RAD_W-1:0] r_i);
        longint cx, cy, r, x0, x1, y0, y1, tx, ty, px, py, dx, dy, w, h;
        bit     blocked;
        cx = cx_i;
        cy = cy_i;
        r  = r_i;
        if (r < 0)
            return 1'b0;
        w  = (map_w > COLS_MAX) ? MAX_COLS : map_w;
        h  = (map_h > ROWS_MAX) ? MAX_ROWS : map_h;
        x0 = (cx - r) >>> FRAC_BITS;
        x1 = (cx + r) >>> FRAC_BITS;
        y0 = (cy - r) >>> FRAC_BITS;
        y1 = (cy + r) >>> FRAC_BITS;
        for (ty = y0; ty <= y1; ty++) begin
            for (tx = x0; tx <= x1; tx++) begin
                if (tx < 0 || tx >= w || ty < 0 || ty >= h)
                    blocked = 1'b1;
                else
                    blocked = wall_map[ty * MAX_COLS + tx];
                if (blocked) begin
                    px = cx;
                    py = cy;
                    if (px < (tx << FRAC_BITS)) px = tx << FRAC_BITS;
                    if (px > ((tx + 1) << FRAC_BITS)) px = (tx + 1) << FRAC_BITS;
                    if (py < (ty << FRAC_BITS)) py = ty << FRAC_BITS;
                    if (py > ((ty + 1) << FRAC_BITS)) py = (ty + 1) << FRAC_BITS;
                    dx = cx - px;
                    dy = cy - py;
                    if (dx * dx + dy * dy < r * r)
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic t_req wr_req(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                    logic wall);
        t_req rq;
        rq.op    = OP_WRITE;
        rq.col   = col;
        rq.row   = row;
        rq.wall  = wall;
        rq.cx    = COORD_W'($urandom);
        rq.cy    = COORD_W'($urandom);
        rq.rad   = RAD_W'($urandom);
        rq.known = 1'b0;
        rq.fits  = 1'b0;
        return rq;
    endfunction

    function automatic t_req qry_req(logic signed [COORD_W-1:0] cx,
                                     logic signed [COORD_W-1:0] cy,
                                     logic signed [RAD_W-1:0] rad,
                                     bit known, logic fits);
        t_req rq;
        rq.op    = OP_QUERY;
        rq.col   = COL_W'($urandom);
        rq.row   = ROW_W'($urandom);
        rq.wall  = 1'($urandom);
        rq.cx    = cx;
        rq.cy    = cy;
        rq.rad   = rad;
        rq.known = known;
        rq.fits  = fits;
        return rq;
    endfunction

    function automatic t_req rand_req();
        logic signed [COORD_W-1:0] cx, cy;
        logic signed [RAD_W-1:0]   rad;
        int                        sel;
        if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 4) != 0)
                return wr_req(COL_W'(hot_x + $urandom_range(0, 11)),
                              ROW_W'(hot_y + $urandom_range(0, 11)),
                              $urandom_range(0, 3) == 0);
            return wr_req(COL_W'($urandom), ROW_W'($urandom), 1'($urandom));
        end
        if ($urandom_range(0, 99) < 85) begin
            cx = COORD_W'(hot_x * 256 + $urandom_range(0, 14 * 256) - 256);
            cy = COORD_W'(hot_y * 256 + $urandom_range(0, 14 * 256) - 256);
            case ($urandom_range(0, 5))
                0: cx[7:0] = 8'h00;
                1: cy[7:0] = 8'h00;
                2: cx[7:0] = 8'h80;
                default: ;
            endcase
        end else begin
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
        end
        sel = $urandom_range(0, 99);
        if (sel < 10)
            rad = '0;
        else if (sel < 20)
            rad = -RAD_W'($urandom_range(1, 1024));
        else if (sel < 65)
            rad = RAD_W'($urandom_range(1, 255));
        else if (sel < 75)
            rad = RAD_W'($urandom_range(1, 7) * 128);
        else
            rad = RAD_W'($urandom_range(256, 1023));
        return qry_req(cx, cy, rad, 1'b0, 1'b0);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'(127);
            3: return DIM_W'($urandom_range(65, 127));
            4, 5: return DIM_RESET;
            default: return DIM_W'($urandom_range(20, 64));
        endcase
    endfunction

    task automatic issue_req(input t_req rq, input int gap_max);
        int gap;
        start           <= 1'b1;
        i_opcode        <= rq.op;
        i_tile_col      <= rq.col;
        i_tile_row      <= rq.row;
        i_tile_is_wall  <= rq.wall;
        i_center_x      <= rq.cx;
        i_center_y      <= rq.cy;
        i_circle_radius <= rq.rad;
        do @(posedge i_clk); while (busy);
        if (rq.op == OP_QUERY)
            fits_due.push_back(rq.known ? rq.fits : predict_fits(rq.cx, rq.cy, rq.rad));
        else
            wall_map[rq.row * MAX_COLS + rq.col] = rq.wall;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (fits_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= REG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        map_w = w;
        map_h = h;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (fits_due.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: fits=%0b with no request pending", $realtime, o_fits);
            end else if (fits_due[0] !== o_fits) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: fits expected %0b, got %0b", $realtime, fits_due[0],
                             o_fits);
                void'(fits_due.pop_front());
            end else begin
                void'(fits_due.pop_front());
            end
        end
    end

    initial begin
        #12_000_000;
        $display("circle_tile_grid_collision_core: mismatch");
        $finish;
    end

    initial begin
        logic [DIM_W-1:0] w, h;
        int               gap_max;
        foreach (wall_map[i]) wall_map[i] = 1'b1;
        map_w = DIM_RESET;
        map_h = DIM_RESET;

        // all tiles blocked after reset
        directed_reqs.push_back(qry_req(16'sh2080, 16'sh2080, 11'sd0, 1'b1, 1'b1));
        directed_reqs.push_back(qry_req(16'sh2080, 16'sh2080, -11'sd1, 1'b1, 1'b0));
        directed_reqs.push_back(qry_req(16'sh2080, 16'sh2080, -11'sd1024, 1'b1, 1'b0));
        directed_reqs.push_back(qry_req(16'sh2080, 16'sh2080, 11'sd1, 1'b1, 1'b0));
        directed_reqs.push_back(qry_req(16'sh7FFF, -16'sh8000, 11'sd1023, 1'b1, 1'b0));
        directed_reqs.push_back(qry_req(-16'sh8000, 16'sh7FFF, 11'sd1023, 1'b1, 1'b0));
        directed_reqs.push_back(wr_req(6'd10, 6'd10, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0A80, 16'sh0A80, 11'sd127, 1'b0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0A80, 16'sh0A80, 11'sd128, 1'b0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0A80, 16'sh0A80, 11'sd129, 1'b0, 1'b0));
        directed_reqs.push_back(wr_req(6'd11, 6'd10, 1'b0));
        directed_reqs.push_back(wr_req(6'd9, 6'd10, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0A80, 16'sh0A80, 11'sd200, 1'b0, 1'b0));
        directed_reqs.push_back(wr_req(6'd0, 6'd0, 1'b0));
        directed_reqs.push_back(wr_req(6'd63, 6'd63, 1'b0));
        directed_reqs.push_back(wr_req(6'd0, 6'd63, 1'b0));
        directed_reqs.push_back(wr_req(6'd63, 6'd0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0080, 16'sh0080, 11'sd128, 1'b0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0080, 16'sh0080, 11'sd129, 1'b0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh3F80, 16'sh3F80, 11'sd128, 1'b0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh3F80, 16'sh0080, 11'sd200, 1'b0, 1'b0));
        directed_reqs.push_back(wr_req(6'd10, 6'd10, 1'b1));
        directed_reqs.push_back(qry_req(16'sh0A80, 16'sh0A80, 11'sd127, 1'b0, 1'b0));
        directed_reqs.push_back(qry_req(16'sh0A00, 16'sh0A00, 11'sd0, 1'b1, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_reqs[i])
            issue_req(directed_reqs[i], 8);

        for (int phase = 0; phase < 14; phase++) begin
            settle();
            case (phase)
                0: begin w = '0;          h = DIM_W'(127); end
                1: begin w = DIM_W'(127); h = '0;          end
                2: begin w = DIM_W'(1);   h = DIM_W'(1);   end
                3: begin w = DIM_RESET;   h = DIM_RESET;   end
                default: begin w = pick_dim(); h = pick_dim(); end
            endcase
            write_dims(w, h);
            hot_x   = $urandom_range(0, 52);
            hot_y   = $urandom_range(0, 52);
            gap_max = (phase % 4 == 3) ? 0 : 8;
            for (int n = 0; n < 100; n++)
                issue_req(rand_req(), gap_max);
        end

        start <= 1'b0;
        while (fits_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (bad_count == 0 && fits_due.size() == 0)
            $display("circle_tile_grid_collision_core: match");
        else
            $display("circle_tile_grid_collision_core: mismatch");
        $finish;
    end

endmodule
